FILE: rtl/mexp_pkg.sv
`default_nettype none

package mexp_pkg;

  // Width of every field on the item ports.
  localparam int unsigned FIELD_W = 63;

  // Default internal operand width.
  localparam int unsigned OPERAND_WIDTH_DEF = 63;

  // Sequencer states of the exponentiation unit.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_REDUCE,
    ST_STEP,
    ST_MUL_R,
    ST_SQUARE,
    ST_DONE
  } mexp_state_e;

  // Status of the shared modular multiplier.
  typedef struct packed {
    logic busy;
    logic done;
  } mm_stat_t;

endpackage

`default_nettype wire

FILE: rtl/mexp_mulmod.sv
`default_nettype none

// Bit-serial modular multiplier: one multiplier bit per cycle.
module mexp_mulmod #(
  parameter int unsigned W = mexp_pkg::OPERAND_WIDTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [W-1:0]     a_i,
  input  wire logic [W-1:0]     b_i,
  input  wire logic [W-1:0]     m_i,
  output mexp_pkg::mm_stat_t    stat_o,
  output logic      [W-1:0]     prod_o
);
  import mexp_pkg::*;

  localparam int unsigned CNT_W = $clog2(W);
  localparam int unsigned WP    = W + 2;

  logic [W-1:0]     a_q, b_q, acc_q;
  logic [W-1:0]     acc_d;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;

  logic [WP-1:0]    t, m1, m2, t_m1, t_m2;

  // The accumulator stays below the modulus, so 2*acc + a is below 3*m and
  // at most two subtractions of m bring it back into range.
  always_comb begin
    t    = {1'b0, acc_q, 1'b0} + {2'b00, (b_q[W-1] ? a_q : '0)};
    m1   = {2'b00, m_i};
    m2   = {1'b0, m_i, 1'b0};
    t_m1 = t - m1;
    t_m2 = t - m2;
    if (t >= m2) begin
      acc_d = t_m2[W-1:0];
    end else if (t >= m1) begin
      acc_d = t_m1[W-1:0];
    end else begin
      acc_d = t[W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      b_q   <= {b_q[W-2:0], 1'b0};
      acc_q <= acc_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign prod_o      = acc_q;

`ifndef NO_ASSERTIONS
  // The partial product is always reduced below the modulus.
  a_acc_reduced : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (acc_q < m_i))
    else $error("mulmod accumulator not reduced");

  // A product finishes in the cycle after its last bit step.
  a_done_after_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("mulmod done without a running product");

  // A product never starts while another is running.
  a_no_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !start_i)
    else $error("mulmod restarted while busy");
`endif

endmodule

`default_nettype wire

FILE: rtl/modular_exponentiation_unit.sv
`default_nettype none

// Sequence: after acceptance the base is reduced modulo the modulus; then, for each exponent bit
// up to the top set bit, a set bit multiplies the result by the base and every bit squares the base.
// A zero modulus skips all arithmetic.
// Throughput: one item at a time; the next item is taken only after the result is
// registered, and the bit-serial multiplier (one bit per cycle, two products per set bit) sets it.
// Reset (rst_ni, asynchronous, active low) returns the sequencer to idle and drops out_valid_o.
module modular_exponentiation_unit #(
  parameter int unsigned OPERAND_WIDTH = mexp_pkg::OPERAND_WIDTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [mexp_pkg::FIELD_W-1:0]  base_value_i,
  input  wire logic [mexp_pkg::FIELD_W-1:0]  exponent_i,
  input  wire logic [mexp_pkg::FIELD_W-1:0]  modulus_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [mexp_pkg::FIELD_W-1:0]  power_result_o,
  output logic                               zero_modulus_error_o
);
  import mexp_pkg::*;

  localparam int unsigned W = OPERAND_WIDTH;

  mexp_state_e state_q, state_d;

  // Working registers: the reduced and repeatedly squared base, the remaining
  // exponent bits, the running result and the modulus.
  logic [W-1:0] b_q, e_q, r_q, m_q;
  logic         err_q;

  logic [FIELD_W-1:0] power_result_q;
  logic               out_err_q;
  logic               out_valid_q;

  logic         in_fire;
  logic         out_free;

  // Shared multiplier controls.
  logic         mm_start;
  logic [W-1:0] mm_a, mm_b;
  logic [W-1:0] mm_prod;
  mm_stat_t     mm_stat;

  assign in_fire  = in_valid_i && !in_stall_o;
  // The output register can take a new result when empty or being drained.
  assign out_free = !out_valid_q || !out_stall_i;

  mexp_mulmod #(
    .W (W)
  ) u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mm_start),
    .a_i     (mm_a),
    .b_i     (mm_b),
    .m_i     (m_q),
    .stat_o  (mm_stat),
    .prod_o  (mm_prod)
  );

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = (modulus_i[W-1:0] == '0) ? ST_DONE : ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_d = ST_REDUCE;
      end
      ST_REDUCE: begin
        if (mm_stat.done) begin
          state_d = ST_STEP;
        end
      end
      ST_STEP: begin
        if (e_q == '0) begin
          state_d = ST_DONE;
        end else if (e_q[0]) begin
          state_d = ST_MUL_R;
        end else begin
          state_d = ST_SQUARE;
        end
      end
      ST_MUL_R: begin
        if (mm_stat.done) begin
          state_d = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        if (mm_stat.done) begin
          state_d = ST_STEP;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output logic of the sequencer: multiplier start and operand selection.
  // The base is reduced as the product 1 * base, which the multiplier
  // handles for every nonzero modulus, including one.
  always_comb begin
    mm_start = 1'b0;
    mm_a     = b_q;
    mm_b     = b_q;
    unique case (state_q)
      ST_LOAD: begin
        mm_start = 1'b1;
        mm_a     = W'(1);
        mm_b     = b_q;
      end
      ST_STEP: begin
        if (e_q != '0) begin
          mm_start = 1'b1;
          mm_a     = e_q[0] ? r_q : b_q;
        end
      end
      ST_MUL_R: begin
        // Squaring starts as soon as the result update is done.
        mm_start = mm_stat.done;
      end
      default: begin
        mm_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_fire) begin
      b_q   <= base_value_i[W-1:0];
      e_q   <= exponent_i[W-1:0];
      m_q   <= modulus_i[W-1:0];
      r_q   <= W'(1);
      err_q <= (modulus_i[W-1:0] == '0);
    end
    if (state_q == ST_REDUCE && mm_stat.done) begin
      b_q <= mm_prod;
    end
    if (state_q == ST_MUL_R && mm_stat.done) begin
      r_q <= mm_prod;
    end
    if (state_q == ST_SQUARE && mm_stat.done) begin
      b_q <= mm_prod;
      e_q <= {1'b0, e_q[W-1:1]};
    end
    if (state_q == ST_DONE && out_free) begin
      power_result_q <= err_q ? '0 : FIELD_W'(r_q);
      out_err_q      <= err_q;
    end
  end

  assign in_stall_o           = (state_q != ST_IDLE);
  assign out_valid_o          = out_valid_q;
  assign power_result_o       = power_result_q;
  assign zero_modulus_error_o = out_err_q;

`ifndef NO_ASSERTIONS
  // An error result always carries a zero power.
  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && zero_modulus_error_o) |-> (power_result_o == '0))
    else $error("zero modulus result is not zero");

  // Arithmetic only runs with a nonzero modulus.
  a_mod_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REDUCE || state_q == ST_STEP || state_q == ST_MUL_R ||
     state_q == ST_SQUARE) |-> (m_q != '0))
    else $error("arithmetic with zero modulus");

  // After reduction the base stays below the modulus.
  a_base_reduced : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP) |-> (b_q < m_q))
    else $error("base not reduced");

  // While waiting on a product, the multiplier is running or just finished.
  a_mul_running : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REDUCE || state_q == ST_MUL_R || state_q == ST_SQUARE) |->
    (mm_stat.busy || mm_stat.done))
    else $error("sequencer waits on an idle multiplier");
`endif

endmodule

`default_nettype wire
